// ----- rtl/core/dipv4_pkg.sv -----
// shared types and codes for the dotted ipv4 text parser
`default_nettype none

package dipv4_pkg;

    // parse phases
    localparam logic [2:0] PH_START  = 3'd0;
    localparam logic [2:0] PH_ZERO   = 3'd1;
    localparam logic [2:0] PH_DIGITS = 3'd2;
    localparam logic [2:0] PH_GOOD   = 3'd3;
    localparam logic [2:0] PH_BAD    = 3'd4;

    // radix codes
    localparam logic [1:0] RX_DEC = 2'd0;
    localparam logic [1:0] RX_OCT = 2'd1;
    localparam logic [1:0] RX_HEX = 2'd2;

    // characters of interest
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;

    // limits on the last part, by number of saved parts
    localparam logic [31:0] LIM_1PART = 32'h00ff_ffff;
    localparam logic [31:0] LIM_2PART = 32'h0000_ffff;
    localparam logic [31:0] LIM_3PART = 32'h0000_00ff;

    typedef struct packed {
        logic [2:0]      phase;
        logic [1:0]      radix;
        logic [31:0]     accum;
        logic [2:0][7:0] saved;
        logic [1:0]      part_count;
    } t_state;

    localparam t_state ST_RESET = '0;

    typedef struct packed {
        logic        emit;
        logic        ok;
        logic [31:0] address;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/core/dipv4_step.sv -----
// next-state and result logic for one character
`default_nettype none

module dipv4_step
    import dipv4_pkg::*;
(
    input  var t_state     i_state,
    input  var logic [7:0] i_ch,
    output t_state         o_state,
    output t_result        o_result
);

    logic        is_digit;
    logic        is_lhex;
    logic        is_uhex;
    logic        is_space;
    logic [31:0] acc;
    logic [1:0]  rad;
    logic [31:0] digit_val;
    logic [31:0] acc_next;
    logic [31:0] asm_addr;
    logic        asm_ok;
    logic        use_digits;
    t_state      st;
    t_result     res;

    always_comb begin
        is_digit = (i_ch >= CH_ZERO) && (i_ch <= CH_NINE);
        is_lhex  = (i_ch >= CH_LA) && (i_ch <= CH_LF);
        is_uhex  = (i_ch >= CH_UA) && (i_ch <= CH_UF);
        is_space = (i_ch == CH_SPACE) || ((i_ch >= CH_TAB) && (i_ch <= CH_CR));

        st         = i_state;
        res        = '0;
        use_digits = 1'b0;
        acc        = i_state.accum;
        rad        = i_state.radix;

        unique case (i_state.phase)
            PH_START: begin
                st.accum = '0;
                acc      = '0;
                if (i_ch == CH_ZERO) begin
                    st.radix = RX_OCT;
                    st.phase = PH_ZERO;
                end else begin
                    rad        = RX_DEC;
                    use_digits = 1'b1;
                end
            end
            PH_ZERO: begin
                if (i_ch == CH_LX || i_ch == CH_UX) begin
                    st.radix = RX_HEX;
                    st.phase = PH_DIGITS;
                end else begin
                    rad        = RX_OCT;
                    use_digits = 1'b1;
                end
            end
            PH_DIGITS: begin
                use_digits = 1'b1;
            end
            PH_GOOD: begin
                if (i_ch == CH_NUL) begin
                    res = '{emit: 1'b1, ok: 1'b1, address: i_state.accum};
                    st  = ST_RESET;
                end
            end
            default: begin
                if (i_ch == CH_NUL) begin
                    res = '{emit: 1'b1, ok: 1'b0, address: '0};
                    st  = ST_RESET;
                end
            end
        endcase

        // digit weight and shift-add for the running part value
        if (is_digit) begin
            digit_val = {24'd0, i_ch - CH_ZERO};
        end else if (is_lhex) begin
            digit_val = {24'd0, i_ch - CH_LA + 8'd10};
        end else begin
            digit_val = {24'd0, i_ch - CH_UA + 8'd10};
        end
        case (rad)
            RX_HEX:  acc_next = {acc[27:0], 4'd0} + digit_val;
            RX_OCT:  acc_next = {acc[28:0], 3'd0} + digit_val;
            default: acc_next = {acc[28:0], 3'd0} + {acc[30:0], 1'b0} + digit_val;
        endcase

        // join saved parts with the last part
        case (i_state.part_count)
            2'd0: begin
                asm_ok   = 1'b1;
                asm_addr = acc;
            end
            2'd1: begin
                asm_ok   = acc <= LIM_1PART;
                asm_addr = acc | {i_state.saved[0], 24'd0};
            end
            2'd2: begin
                asm_ok   = acc <= LIM_2PART;
                asm_addr = acc | {i_state.saved[0], i_state.saved[1], 16'd0};
            end
            default: begin
                asm_ok   = acc <= LIM_3PART;
                asm_addr = acc | {i_state.saved[0], i_state.saved[1], i_state.saved[2], 8'd0};
            end
        endcase

        if (use_digits) begin
            st.phase = PH_DIGITS;
            st.radix = rad;
            if (is_digit || (rad == RX_HEX && (is_lhex || is_uhex))) begin
                st.accum = acc_next;
            end else if (i_ch == CH_DOT) begin
                if (i_state.part_count == 2'd3 || acc > LIM_3PART) begin
                    st.phase = PH_BAD;
                end else begin
                    st.saved[i_state.part_count] = acc[7:0];
                    st.part_count = i_state.part_count + 2'd1;
                    st.accum      = '0;
                    st.radix      = RX_DEC;
                    st.phase      = PH_START;
                end
            end else if (i_ch == CH_NUL) begin
                res = '{emit: 1'b1, ok: asm_ok, address: asm_ok ? asm_addr : 32'd0};
                st  = ST_RESET;
            end else if (is_space && asm_ok) begin
                st.accum = asm_addr;
                st.phase = PH_GOOD;
            end else begin
                st.phase = PH_BAD;
            end
        end

        o_state  = st;
        o_result = res;
    end

endmodule

`default_nettype wire

// ----- rtl/core/dotted_ipv4_text_parser_core.sv -----
// top level of the dotted ipv4 text parser
//
// input channel: one character per item on i_ch with i_in_valid / o_in_ready;
//   a zero character ends the string
// output channel: one item per string on o_ok / o_address with
//   o_out_valid / i_out_ready; o_address holds the first of several parts in
//   bits 31..24 and is zero when o_ok is low
// every character passes an input register, then a single pass of the
//   step logic updates the parse state and, for the terminating zero,
//   loads the result register
// the terminating zero passes the input register, then its result is held in
//   the result register; throughput is one character per cycle while the receiver does not stall
// when the receiver stalls with a result held, the input register keeps
//   one more character and o_in_ready drops until the result is taken
// reset (i_rst_n low, synchronous) clears the parse state to the start of
//   the first part and empties both registers
`default_nettype none

module dotted_ipv4_text_parser_core
    import dipv4_pkg::*;
(
    input  var logic        i_clk,
    input  var logic        i_rst_n,
    input  var logic        i_in_valid,
    output logic            o_in_ready,
    input  var logic [7:0]  i_ch,
    output logic            o_out_valid,
    input  var logic        i_out_ready,
    output logic            o_ok,
    output logic [31:0]     o_address
);

    // input register
    logic        r_in_valid;
    logic [7:0]  r_ch;
    // parse state
    t_state      r_state;
    t_state      n_state;
    t_result     step_res;
    // result register
    logic        r_out_valid;
    logic        r_ok;
    logic [31:0] r_address;

    logic        advance;

    // the step stage moves on whenever the result register is free or freeing
    assign advance    = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || advance;

    dipv4_step u_step (
        .i_state  (r_state),
        .i_ch     (r_ch),
        .o_state  (n_state),
        .o_result (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_ch <= i_ch;
        end
    end

    // parse state advances once per character leaving the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RESET;
        end else if (r_in_valid && advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid && step_res.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid && step_res.emit) begin
            r_ok      <= step_res.ok;
            r_address <= step_res.address;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_ok        = r_ok;
    assign o_address   = r_address;

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// testbench for the dotted ipv4 text parser core, checked against a built-in parse predictor
`timescale 1ns / 1ps

module testbench
    import dipv4_pkg::*;
();

    typedef struct packed {
        logic        ok;
        logic [31:0] address;
    } t_addr_result;

    typedef enum int {
        FMT_DEC,
        FMT_OCT,
        FMT_HEX
    } t_part_fmt;

    // predicts the parse of each accepted character and holds the addresses still due
    class addr_parse_scoreboard;
        logic [2:0]   phase;
        logic [1:0]   radix;
        logic [31:0]  accum;
        logic [7:0]   saved [3];
        logic [1:0]   part_count;
        t_addr_result expected_addrs [$];
        int unsigned  errors;
        int unsigned  strings_checked;
        int unsigned  strings_ok;

        function new();
            clear_parse();
            errors = 0;
            strings_checked = 0;
            strings_ok = 0;
        endfunction

        function void clear_parse();
            phase = PH_START;
            radix = RX_DEC;
            accum = '0;
            foreach (saved[i]) saved[i] = '0;
            part_count = '0;
        endfunction

        function bit is_blank(input logic [7:0] c);
            return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
        endfunction

        // the last part fills whatever bytes the saved parts leave free
        function bit join_parts(input logic [31:0] last, output logic [31:0] joined);
            joined = last;
            case (part_count)
                2'd0: return 1'b1;
                2'd1: begin
                    joined = last | {saved[0], 24'h0};
                    return last <= LIM_1PART;
                end
                2'd2: begin
                    joined = last | {saved[0], saved[1], 16'h0};
                    return last <= LIM_2PART;
                end
                default: begin
                    joined = last | {saved[0], saved[1], saved[2], 8'h0};
                    return last <= LIM_3PART;
                end
            endcase
        endfunction

        function void push_result(input logic ok, input logic [31:0] address);
            t_addr_result r;
            r.ok = ok;
            r.address = ok ? address : 32'h0;
            expected_addrs.push_back(r);
            clear_parse();
        endfunction

        function void digit_step(input logic [7:0] c);
            logic [31:0] joined;
            logic [31:0] base;
            logic        fits;
            phase = PH_DIGITS;
            base = (radix == RX_HEX) ? 32'd16 : ((radix == RX_OCT) ? 32'd8 : 32'd10);
            if (c >= CH_ZERO && c <= CH_NINE) begin
                accum = accum * base + 32'(c - CH_ZERO);
            end else if (radix == RX_HEX && c >= CH_LA && c <= CH_LF) begin
                accum = {accum[27:0], 4'h0} + 32'(c - CH_LA) + 32'd10;
            end else if (radix == RX_HEX && c >= CH_UA && c <= CH_UF) begin
                accum = {accum[27:0], 4'h0} + 32'(c - CH_UA) + 32'd10;
            end else if (c == CH_DOT) begin
                // a fifth part or an early part above 255 kills the string
                if (part_count == 2'd3 || accum > 32'hff) begin
                    phase = PH_BAD;
                end else begin
                    saved[part_count] = accum[7:0];
                    part_count++;
                    accum = '0;
                    radix = RX_DEC;
                    phase = PH_START;
                end
            end else if (c == CH_NUL) begin
                fits = join_parts(accum, joined);
                push_result(fits, joined);
            end else if (is_blank(c) && join_parts(accum, joined)) begin
                accum = joined;
                phase = PH_GOOD;
            end else begin
                phase = PH_BAD;
            end
        endfunction

        function void note_char(input logic [7:0] c);
            case (phase)
                PH_START: begin
                    accum = '0;
                    if (c == CH_ZERO) begin
                        radix = RX_OCT;
                        phase = PH_ZERO;
                    end else begin
                        radix = RX_DEC;
                        digit_step(c);
                    end
                end
                PH_ZERO: begin
                    if (c == CH_LX || c == CH_UX) begin
                        radix = RX_HEX;
                        phase = PH_DIGITS;
                    end else begin
                        radix = RX_OCT;
                        digit_step(c);
                    end
                end
                PH_DIGITS: digit_step(c);
                PH_GOOD: if (c == CH_NUL) push_result(1'b1, accum);
                default: if (c == CH_NUL) push_result(1'b0, 32'h0);
            endcase
        endfunction

        function void report_error(input string msg);
            errors++;
            if (errors <= 10) $display("mismatch at %0t: %s", $realtime, msg);
        endfunction

        function void check_addr(input logic ok, input logic [31:0] address);
            t_addr_result want;
            if (expected_addrs.size() == 0) begin
                report_error($sformatf("unexpected result ok=%0b address=%h", ok, address));
                return;
            end
            want = expected_addrs.pop_front();
            strings_checked++;
            if (want.ok) strings_ok++;
            if (ok !== want.ok)
                report_error($sformatf("ok expected %0b got %0b", want.ok, ok));
            if (address !== want.address)
                report_error($sformatf("address expected %h got %h", want.address, address));
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [7:0]  i_ch = '0;
    logic        i_out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic        o_ok;
    logic [31:0] o_address;

    addr_parse_scoreboard sb = new();

    logic [7:0]  text [$];
    int unsigned chars_sent = 0;
    int unsigned in_idle_pct = 0;
    int unsigned out_stall_pct = 0;
    int unsigned idle_mix [4] = '{0, 79, 0, 15};
    int unsigned stall_mix [4] = '{0, 0, 79, 15};

    dotted_ipv4_text_parser_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_ch        (i_ch),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_ok        (o_ok),
        .o_address   (o_address)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver: check on handshake, then pick ready for the next cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_addr(o_ok, o_address);
        i_out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
    end

    task automatic send_char(input logic [7:0] c);
        while ($urandom_range(0, 99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_ch <= c;
        do @(posedge i_clk); while (!o_in_ready);
        chars_sent++;
        sb.note_char(c);
    endtask

    task automatic finish_text();
        text.push_back(CH_NUL);
        foreach (text[i]) send_char(text[i]);
        text.delete();
    endtask

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
    endtask

    task automatic send_str(input string s);
        put_str(s);
        finish_text();
    endtask

    task automatic put_digits(input logic [31:0] v, input int unsigned base, input bit upper);
        logic [7:0] rev [$];
        logic [3:0] d;
        do begin
            d = 4'(v % base);
            rev.push_front((d < 4'd10) ? CH_ZERO + 8'(d)
                                       : (upper ? CH_UA : CH_LA) + 8'(d) - 8'd10);
            v = v / base;
        end while (v != 0);
        foreach (rev[i]) text.push_back(rev[i]);
    endtask

    task automatic put_part(input logic [31:0] v, input t_part_fmt fmt);
        case (fmt)
            FMT_DEC: put_digits(v, 10, 1'b0);
            FMT_OCT: begin
                text.push_back(CH_ZERO);
                put_digits(v, 8, 1'b0);
            end
            default: begin
                text.push_back(CH_ZERO);
                text.push_back($urandom_range(0, 1) ? CH_UX : CH_LX);
                put_digits(v, 16, 1'($urandom_range(0, 1)));
            end
        endcase
    endtask

    task automatic put_blank();
        text.push_back($urandom_range(0, 5) == 5 ? CH_SPACE : 8'($urandom_range(9, 13)));
    endtask

    // mostly in-range addresses, with parts at and just past their limits
    task automatic put_address();
        int unsigned nparts;
        int unsigned pick;
        logic [31:0] v;
        logic [31:0] lim;
        nparts = $urandom_range(1, 4);
        for (int unsigned k = 1; k <= nparts; k++) begin
            pick = $urandom_range(0, 99);
            if (k < nparts) begin
                lim = 32'hff;
                pick = pick / 4 + 60;
            end else begin
                case (nparts)
                    1: lim = 32'hffff_ffff;
                    2: lim = LIM_1PART;
                    3: lim = LIM_2PART;
                    default: lim = LIM_3PART;
                endcase
            end
            if (pick < 80) v = $urandom_range(0, lim);
            else if (pick < 90) v = lim;
            else if (pick < 95) v = lim + 32'd1;
            else v = $urandom;
            pick = $urandom_range(0, 29);
            if (pick == 1) begin
                // bare hex prefix
                text.push_back(CH_ZERO);
                text.push_back(CH_LX);
            end else if (pick == 2) begin
                // raw digit run: octal eights and nines, decimal wrap
                repeat ($urandom_range(1, 12)) text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
            end else if (pick != 0) begin
                put_part(v, t_part_fmt'($urandom_range(0, 2)));
            end
            if (k < nparts) text.push_back(CH_DOT);
        end
        pick = $urandom_range(0, 9);
        if (pick == 6 || pick == 7) begin
            put_blank();
            repeat ($urandom_range(0, 4)) text.push_back(8'($urandom_range(1, 255)));
        end else if (pick == 8) begin
            text.push_back(8'($urandom_range(1, 255)));
        end else if (pick == 9) begin
            text.push_back(CH_DOT);
            put_part($urandom_range(0, 300), t_part_fmt'($urandom_range(0, 2)));
        end
    endtask

    task automatic put_noise();
        string alpha = "0123456789.xXafAF \t";
        repeat ($urandom_range(0, 10)) begin
            if ($urandom_range(0, 1)) text.push_back(8'($urandom_range(1, 255)));
            else text.push_back(alpha[$urandom_range(0, alpha.len() - 1)]);
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_str("");
        send_str("255.255.255.255");
        send_str("0.0.0.0");
        send_str("4294967295");
        send_str("4294967296");
        send_str("0x7f.1\015");
        send_str("0XfF.0xAb.0377.09");
        send_str("08.09");
        send_str("1..2");
        send_str("0x");
        send_str("1.2.3.4.5");
        send_str("256.1");
        send_str("1.16777215\n");
        send_str("1.16777216");
        send_str("1.2.65535\013");
        send_str("1.2.65536");
        send_str("1.2.3.255\014");
        send_str("1.2.3.256");
        send_str("10.0.0.1\t.x9");
        send_str("1.2.3.4x");
        send_str(" ");
        put_str("7");
        text.push_back(8'h80);
        finish_text();
        put_str("1.2.3.4 ");
        text.push_back(8'hff);
        finish_text();

        for (int ph = 0; ph < 4; ph++) begin
            int unsigned phase_end;
            in_idle_pct = idle_mix[ph];
            out_stall_pct = stall_mix[ph];
            phase_end = chars_sent + 250;
            while (chars_sent < phase_end) begin
                if ($urandom_range(0, 99) < 80) put_address();
                else put_noise();
                finish_text();
            end
        end
        i_in_valid <= 1'b0;

        while (sb.expected_addrs.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("sent %0d characters; %0d strings checked, %0d valid and %0d rejected",
                 chars_sent, sb.strings_checked, sb.strings_ok,
                 sb.strings_checked - sb.strings_ok);
        $display("flow control mixes: none, sender idle 79%%, receiver stall 79%%, both 15%%");
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches in total", sb.errors);
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d results outstanding", sb.expected_addrs.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
